>>> rtl/fdsc_pkg.sv
// ----------------------------------------------------------------------------
// fdsc_pkg
// shared types, constants and helpers of the scanned up/down display counter
// ----------------------------------------------------------------------------
package fdsc_pkg;

    localparam int SW_W     = 8;
    localparam int SEG_W    = 8;
    localparam int DEN_W    = 4;
    localparam int VALUE_W  = 14;
    localparam int ROUNDS_W = 10;
    localparam int CMD_W    = 4;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 32;

    localparam logic [VALUE_W-1:0]  TOP_VALUE = 14'd9999;
    localparam logic [ROUNDS_W-1:0] RPU_RESET = 10'd100;

    // latched commands
    localparam logic [CMD_W-1:0] CMD_NONE = 4'd0;
    localparam logic [CMD_W-1:0] CMD_UP1  = 4'd1;
    localparam logic [CMD_W-1:0] CMD_DN1  = 4'd2;
    localparam logic [CMD_W-1:0] CMD_UP2  = 4'd4;
    localparam logic [CMD_W-1:0] CMD_DN2  = 4'd8;

    // scan phases
    localparam logic [1:0] PHASE_UNITS     = 2'd0;
    localparam logic [1:0] PHASE_TENS      = 2'd1;
    localparam logic [1:0] PHASE_HUNDREDS  = 2'd2;
    localparam logic [1:0] PHASE_THOUSANDS = 2'd3;

    typedef logic [3:0]             bcd_digit_t;
    typedef bcd_digit_t [3:0]       bcd_word_t;

    // current display state handed from the counter to the decoder
    typedef struct packed {
        logic [1:0]         phase;
        bcd_word_t          digits;
        logic [VALUE_W-1:0] value;
    } fdsc_view_t;

    // segment pattern of one decimal digit, decimal point always lit
    function automatic logic [SEG_W-1:0] seg_of(input bcd_digit_t d);
        logic [SEG_W-1:0] s;
        case (d)
            4'd0:    s = 8'hBF;
            4'd1:    s = 8'h86;
            4'd2:    s = 8'hDB;
            4'd3:    s = 8'hCF;
            4'd4:    s = 8'hE6;
            4'd5:    s = 8'hED;
            4'd6:    s = 8'hFD;
            4'd7:    s = 8'h87;
            4'd8:    s = 8'hFF;
            4'd9:    s = 8'hEF;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

    // bcd add of 1 or 2, carry ripples through four digits
    function automatic bcd_word_t bcd_add(input bcd_word_t w, input logic [1:0] mag);
        bcd_word_t  r;
        logic [4:0] acc;
        logic [4:0] adj;
        logic [1:0] carry;
        carry = mag;
        for (int i = 0; i < 4; i++)
        begin
            acc = {1'b0, w[i]} + {3'b000, carry};
            adj = acc - 5'd10;
            if (acc > 5'd9)
            begin
                r[i]  = adj[3:0];
                carry = 2'd1;
            end
            else
            begin
                r[i]  = acc[3:0];
                carry = 2'd0;
            end
        end
        return r;
    endfunction

    // bcd subtract of 1 or 2, borrow ripples through four digits
    function automatic bcd_word_t bcd_sub(input bcd_word_t w, input logic [1:0] mag);
        bcd_word_t  r;
        logic [4:0] acc;
        logic [4:0] adj;
        logic [1:0] borrow;
        borrow = mag;
        for (int i = 0; i < 4; i++)
        begin
            acc = {1'b0, w[i]} - {3'b000, borrow};
            adj = acc + 5'd10;
            if (acc[4])
            begin
                r[i]   = adj[3:0];
                borrow = 2'd1;
            end
            else
            begin
                r[i]   = acc[3:0];
                borrow = 2'd0;
            end
        end
        return r;
    endfunction

endpackage

>>> rtl/four_digit_scanned_updown_counter.sv
// ----------------------------------------------------------------------------
// four_digit_scanned_updown_counter
// multiplexed four-digit seven-segment display of a 0..9999 up/down counter
// ----------------------------------------------------------------------------
// the result of an input transfer is held in the output register from the cycle after it
// throughput: one scan tick per cycle while the receiver is ready, set by the single output
// register stage, which keeps taking ticks while its result drains
// reset: asynchronous active low; units phase, round count zero, no command,
// counter zero, rounds_per_update back to 100; no clearing pass needed
// ----------------------------------------------------------------------------
module four_digit_scanned_updown_counter
    import fdsc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // scan tick in
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,     // [7:0] switches
    // display drive out
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,     // [7:0] segments, [11:8] digit_enable,
                                                // [25:12] shown_value, [31:26] zero
    // rounds_per_update register
    input  logic                   cfg_wr_en,
    input  logic [ROUNDS_W-1:0]    cfg_wr_data
);

    fdsc_view_t              view;
    logic                    accept;
    logic [SEG_W-1:0]        segments;
    logic [DEN_W-1:0]        digit_enable;
    logic                    m_tvalid_reg;
    logic [OUT_TDATA_W-1:0]  m_tdata_reg;

    // the output register takes a new tick whenever it is empty or draining
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // state advances on every accepted tick; the view shows the value before it
    fdsc_counter u_counter (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .switches    (s_tdata[SW_W-1:0]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .view        (view)
    );

    // digit select and segment lookup for the current phase
    fdsc_display u_display (
        .view         (view),
        .segments     (segments),
        .digit_enable (digit_enable)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            m_tvalid_reg <= s_tvalid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_tdata_reg <= {6'd0, view.value, digit_enable, segments};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // every accepted tick leaves a result in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("accepted tick produced no result");

    // exactly one digit driven on every result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $onehot(m_tdata[11:8]))
        else $error("digit enable not one-hot");

    // shown value never leaves the decimal range
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[25:12] <= TOP_VALUE))
        else $error("shown value above 9999");

    // binary and bcd copies of the counter stay in step
    assert property (@(posedge clk) disable iff (!rst_n)
        view.value == ({10'd0, view.digits[0]}
                     + 14'd10   * {10'd0, view.digits[1]}
                     + 14'd100  * {10'd0, view.digits[2]}
                     + 14'd1000 * {10'd0, view.digits[3]}))
        else $error("bcd digits disagree with binary counter");

endmodule

>>> rtl/fdsc_counter.sv
// ----------------------------------------------------------------------------
// fdsc_counter
// scan phase, round count, command latch and the 0..9999 counter kept in
// binary and bcd side by side
// ----------------------------------------------------------------------------
module fdsc_counter
    import fdsc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [SW_W-1:0]     switches,
    input  logic                cfg_wr_en,
    input  logic [ROUNDS_W-1:0] cfg_wr_data,
    output fdsc_view_t          view
);

    logic [ROUNDS_W-1:0] rpu_reg;
    logic [1:0]          phase_reg;
    logic [ROUNDS_W-1:0] round_reg;
    logic [CMD_W-1:0]    cmd_reg;
    bcd_word_t           digits_reg;
    logic [VALUE_W-1:0]  value_reg;

    logic [ROUNDS_W-1:0] round_inc;
    logic                last_tick;
    logic                update;
    logic                sw_valid;
    logic [CMD_W-1:0]    cmd_next;
    logic                step_up;
    logic                step_dn;
    logic [1:0]          mag;
    logic [VALUE_W:0]    sum_wide;
    logic                wrap_hi;
    logic                wrap_lo;
    logic [VALUE_W-1:0]  value_next;
    bcd_word_t           digits_next;

    assign round_inc = round_reg + 10'd1;
    assign last_tick = (phase_reg == PHASE_THOUSANDS);
    assign update    = accept && last_tick && (round_inc >= rpu_reg);

    assign sw_valid = (switches == {4'd0, CMD_UP1}) || (switches == {4'd0, CMD_DN1})
                   || (switches == {4'd0, CMD_UP2}) || (switches == {4'd0, CMD_DN2});
    assign cmd_next = sw_valid ? switches[CMD_W-1:0] : cmd_reg;

    always_comb
    begin
        step_up = 1'b0;
        step_dn = 1'b0;
        mag     = 2'd0;
        case (cmd_next)
            CMD_UP1:
            begin
                step_up = 1'b1;
                mag     = 2'd1;
            end
            CMD_DN1:
            begin
                step_dn = 1'b1;
                mag     = 2'd1;
            end
            CMD_UP2:
            begin
                step_up = 1'b1;
                mag     = 2'd2;
            end
            CMD_DN2:
            begin
                step_dn = 1'b1;
                mag     = 2'd2;
            end
            default:
            begin
                step_up = 1'b0;
                step_dn = 1'b0;
                mag     = 2'd0;
            end
        endcase
    end

    assign sum_wide = {1'b0, value_reg} + {13'd0, mag};
    assign wrap_hi  = step_up && (sum_wide > {1'b0, TOP_VALUE});
    assign wrap_lo  = step_dn && (value_reg < {12'd0, mag});

    always_comb
    begin
        value_next  = value_reg;
        digits_next = digits_reg;
        if (wrap_hi)
        begin
            value_next  = '0;
            digits_next = '0;
        end
        else if (wrap_lo)
        begin
            value_next  = TOP_VALUE;
            digits_next = {4'd9, 4'd9, 4'd9, 4'd9};
        end
        else if (step_up)
        begin
            value_next  = sum_wide[VALUE_W-1:0];
            digits_next = bcd_add(digits_reg, mag);
        end
        else if (step_dn)
        begin
            value_next  = value_reg - {12'd0, mag};
            digits_next = bcd_sub(digits_reg, mag);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rpu_reg    <= RPU_RESET;
            phase_reg  <= PHASE_UNITS;
            round_reg  <= '0;
            cmd_reg    <= CMD_NONE;
            digits_reg <= '0;
            value_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                rpu_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                phase_reg <= phase_reg + 2'd1;
                if (last_tick)
                begin
                    round_reg <= update ? '0 : round_inc;
                end
            end
            if (update)
            begin
                cmd_reg    <= cmd_next;
                digits_reg <= digits_next;
                value_reg  <= value_next;
            end
        end
    end

    assign view.phase  = phase_reg;
    assign view.digits = digits_reg;
    assign view.value  = value_reg;

endmodule

>>> rtl/fdsc_display.sv
// ----------------------------------------------------------------------------
// fdsc_display
// picks the scanned digit and turns it into segments and a digit enable
// ----------------------------------------------------------------------------
module fdsc_display
    import fdsc_pkg::*;
(
    input  fdsc_view_t        view,
    output logic [SEG_W-1:0]  segments,
    output logic [DEN_W-1:0]  digit_enable
);

    bcd_digit_t digit;

    always_comb
    begin
        case (view.phase)
            PHASE_UNITS:
            begin
                digit        = view.digits[0];
                digit_enable = 4'b1000;
            end
            PHASE_TENS:
            begin
                digit        = view.digits[1];
                digit_enable = 4'b0100;
            end
            PHASE_HUNDREDS:
            begin
                digit        = view.digits[2];
                digit_enable = 4'b0010;
            end
            PHASE_THOUSANDS:
            begin
                digit        = view.digits[3];
                digit_enable = 4'b0001;
            end
            default:
            begin
                digit        = view.digits[0];
                digit_enable = 4'b1000;
            end
        endcase
    end

    assign segments = seg_of(digit);

endmodule

>>> tb/four_digit_scanned_updown_counter_tb.sv
// ----------------------------------------------------------------------------
// four_digit_scanned_updown_counter_tb
// drives scan ticks into the display counter, predicts every display word from
// a local model of the scan, the round count and the up/down counter, and
// compares each output transfer field by field under random idling on both
// sides, a long output stall and several rounds_per_update settings
// ----------------------------------------------------------------------------
module four_digit_scanned_updown_counter_tb
    import fdsc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // segment byte of each decimal digit, decimal point lit
    localparam logic [SEG_W-1:0] DIGIT_GLYPH [10] = '{
        8'hBF, 8'h86, 8'hDB, 8'hCF, 8'hE6, 8'hED, 8'hFD, 8'h87, 8'hFF, 8'hEF
    };

    // the four switch values that latch a motion
    localparam logic [CMD_W-1:0] MOTION [4] = '{CMD_UP1, CMD_DN1, CMD_UP2, CMD_DN2};

    // one display word as it leaves the block
    typedef struct {
        logic [SEG_W-1:0]   segments;
        logic [DEN_W-1:0]   digit_enable;
        logic [VALUE_W-1:0] shown_value;
    } display_word_t;

    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata     = '0;     // [7:0] switches
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;              // [7:0] segments, [11:8] digit_enable,
                                                  // [25:12] shown_value, [31:26] zero
    logic                   cfg_wr_en   = 1'b0;
    logic [ROUNDS_W-1:0]    cfg_wr_data = '0;

    // display words still to come, oldest first
    display_word_t pending_display [$];

    // local copy of the block state
    logic [ROUNDS_W-1:0] pr_rounds;
    logic [1:0]          pr_phase;
    logic [ROUNDS_W-1:0] pr_round_count;
    logic [CMD_W-1:0]    pr_cmd;
    logic [VALUE_W-1:0]  pr_value;

    // idling percentages and the long output stall
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int stall_request = 0;
    int stall_left = 0;

    // bookkeeping
    int n_errors = 0;
    int ticks_sent = 0;
    int words_checked = 0;
    int counter_updates = 0;
    int range_wraps = 0;
    int rounds_writes = 0;

    four_digit_scanned_updown_counter DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // display word of one accepted tick, then advance scan, round count and counter
    function automatic void predict_tick(input logic [SW_W-1:0] sw);
        display_word_t           word;
        int unsigned             digit;
        int                      next_value;
        logic [ROUNDS_W-1:0]     next_round;
        digit = 32'(pr_value);
        for (int i = 0; i < pr_phase; i++)
            digit = digit / 10;
        digit = digit % 10;
        word.segments     = DIGIT_GLYPH[digit];
        word.digit_enable = 4'b1000 >> pr_phase;
        word.shown_value  = pr_value;
        pending_display.push_back(word);

        // only the thousands tick closes a round
        if (pr_phase == PHASE_THOUSANDS)
        begin
            next_round = pr_round_count + 10'd1;
            // a zero register or one lowered below the count updates at once
            if (next_round >= pr_rounds)
            begin
                pr_round_count = '0;
                counter_updates++;
                // only a single set switch, one of the low four, latches a command
                if (sw == {4'b0, CMD_UP1} || sw == {4'b0, CMD_DN1} ||
                    sw == {4'b0, CMD_UP2} || sw == {4'b0, CMD_DN2})
                    pr_cmd = sw[CMD_W-1:0];
                next_value = int'(pr_value);
                case (pr_cmd)
                    CMD_UP1: next_value = next_value + 1;
                    CMD_DN1: next_value = next_value - 1;
                    CMD_UP2: next_value = next_value + 2;
                    CMD_DN2: next_value = next_value - 2;
                    default: ;
                endcase
                // overshoot by one or two lands on the far end, not past it
                if (next_value > int'(TOP_VALUE))
                begin
                    next_value = 0;
                    range_wraps++;
                end
                else if (next_value < 0)
                begin
                    next_value = int'(TOP_VALUE);
                    range_wraps++;
                end
                pr_value = next_value[VALUE_W-1:0];
            end
            else
                pr_round_count = next_round;
        end
        pr_phase = pr_phase + 2'd1;
    endfunction

    // ------------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------------

    // offer one scan tick, with random gaps ahead of it, until it is taken
    task automatic send_tick(input logic [SW_W-1:0] sw);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sw;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_tick(sw);
        ticks_sent++;
    endtask

    // write rounds_per_update once every display word is out
    task automatic write_rounds(input logic [ROUNDS_W-1:0] rounds);
        s_tvalid <= 1'b0;
        while (pending_display.size() != 0)
            @(posedge clk);
        // the block has one register stage, so it is quiet before the write
        repeat (2) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= rounds;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        pr_rounds = rounds;
        rounds_writes++;
    endtask

    // receiver: random ready, or held low through a requested stall
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (stall_request > 0)
        begin
            stall_left = stall_request - 1;
            stall_request = 0;
            m_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------

    // compare every output transfer with the oldest expected display word
    always @(posedge clk)
    begin
        display_word_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_display.size() == 0)
            begin
                $error("display transfer %h with no tick waiting", m_tdata);
                n_errors++;
            end
            else
            begin
                want = pending_display.pop_front();
                words_checked++;
                if (m_tdata[7:0] !== want.segments)
                begin
                    $error("segments: expected %h, got %h", want.segments, m_tdata[7:0]);
                    n_errors++;
                end
                if (m_tdata[11:8] !== want.digit_enable)
                begin
                    $error("digit_enable: expected %b, got %b",
                           want.digit_enable, m_tdata[11:8]);
                    n_errors++;
                end
                if (m_tdata[25:12] !== want.shown_value)
                begin
                    $error("shown_value: expected %0d, got %0d",
                           want.shown_value, m_tdata[25:12]);
                    n_errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // after reset the register holds 100 rounds, so commands do not move yet
    task automatic test_power_on_state();
        src_idle_pct = 21;
        snk_idle_pct = 77;
        for (int i = 0; i < 8; i++)
            send_tick((pr_phase == PHASE_THOUSANDS) ? {4'b0, CMD_UP1} : 8'h00);
    endtask

    // every command and both wraps, one update per round with a zero register
    task automatic test_command_wraps();
        logic [SW_W-1:0] last_tick [6];
        // down past zero, +2 past the top, -2 past zero, +1 past the top,
        // then two invalid values that keep the +1 going
        last_tick = '{{4'b0, CMD_DN1}, {4'b0, CMD_UP2}, {4'b0, CMD_DN2},
                      {4'b0, CMD_UP1}, 8'h03, 8'hFF};
        write_rounds(10'd0);
        for (int r = 0; r < 6; r++)
        begin
            send_tick(8'hFF);
            send_tick(8'h00);
            send_tick(8'h10);
            send_tick(last_tick[r]);
        end
    endtask

    // lowering the register below the current round count updates next round
    task automatic test_rounds_lowered();
        write_rounds(10'd3);
        for (int i = 0; i < 8; i++)
            send_tick((pr_phase == PHASE_THOUSANDS) ? {4'b0, CMD_UP2} : 8'h80);
        write_rounds(10'd1);
        for (int i = 0; i < 4; i++)
            send_tick((pr_phase == PHASE_THOUSANDS) ? {4'b0, CMD_DN1} : 8'h01);
    endtask

    // long receiver stall with the sender always offering: the block fills up
    task automatic test_output_backpressure();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        stall_request = 300;
        for (int i = 0; i < 48; i++)
            send_tick((pr_phase == PHASE_THOUSANDS) ? {4'b0, MOTION[$urandom_range(3)]}
                                                    : 8'($urandom_range(255)));
    endtask

    // mostly small round counts so updates are frequent, extremes now and then
    function automatic logic [ROUNDS_W-1:0] pick_rounds();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55)
            return ROUNDS_W'($urandom_range(1, 3));
        else if (pick < 68)
            return '0;
        else if (pick < 76)
            return 10'd1023;
        else if (pick < 84)
            return RPU_RESET;
        else
            return ROUNDS_W'($urandom_range(4, 12));
    endfunction

    // random ticks; the thousands tick mostly carries a valid command, biased
    // toward one motion at a time so the counter walks across the wraps
    task automatic test_random_traffic(input int n_ticks, input int src_pct,
                                       input int snk_pct);
        int              favored;
        logic [SW_W-1:0] sw;
        favored = 0;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        for (int i = 0; i < n_ticks; i++)
        begin
            if (i % 150 == 0)
                write_rounds(pick_rounds());
            if (i % 40 == 0)
                favored = $urandom_range(3);
            if (pr_phase == PHASE_THOUSANDS && $urandom_range(99) < 75)
                sw = ($urandom_range(99) < 70) ? {4'b0, MOTION[favored]}
                                               : {4'b0, MOTION[$urandom_range(3)]};
            else
                sw = 8'($urandom_range(255));
            send_tick(sw);
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------

    initial
    begin
        // local state mirrors the reset values
        pr_rounds      = RPU_RESET;
        pr_phase       = PHASE_UNITS;
        pr_round_count = '0;
        pr_cmd         = CMD_NONE;
        pr_value       = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_on_state();
        test_command_wraps();
        test_rounds_lowered();
        test_output_backpressure();
        test_random_traffic(570, 21, 77);
        test_random_traffic(570, 77, 21);
        test_random_traffic(570, 0, 0);

        // let the last display words drain
        s_tvalid <= 1'b0;
        snk_idle_pct = 0;
        while (pending_display.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("covered %0d scan ticks, %0d display words checked, %0d register writes",
                 ticks_sent, words_checked, rounds_writes);
        $display("counter moved on %0d round ends, wrapping at the range ends %0d times",
                 counter_updates, range_wraps);
        if (n_errors == 0 && pending_display.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
